// ===== src/fsge_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsge_pkg
// Shared types and constants of the falling sand grid engine.
// ----------------------------------------------------------------------------
package fsge_pkg;
    typedef enum logic [1:0] {
        CMD_SWEEP = 2'd0,
        CMD_PAINT = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [2:0] KIND_EMPTY = 3'd0;
    localparam logic [2:0] KIND_SAND  = 3'd1;
    localparam logic [2:0] KIND_WATER = 3'd2;
    localparam logic [2:0] KIND_STONE = 3'd3;
    localparam logic [2:0] KIND_WOOD  = 3'd4;

    localparam logic [15:0] LFSR_MASK = 16'hB400;

    localparam logic       REG_PAINT_TYPE  = 1'b0;
    localparam logic       REG_RANDOM_SEED = 1'b1;

    function automatic logic [7:0] kind_mass(input logic [2:0] k);
        logic [7:0] m;
        case (k)
            KIND_SAND:  m = 8'd100;
            KIND_WATER: m = 8'd50;
            KIND_STONE: m = 8'd200;
            KIND_WOOD:  m = 8'd150;
            default:    m = 8'd0;
        endcase
        return m;
    endfunction
endpackage
`default_nettype wire

// ===== src/fsge_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsge_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/falling_sand_grid_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// falling_sand_grid_engine
// Falling sand cellular automaton over a grid held in block RAM.
// ----------------------------------------------------------------------------
// One command is worked at a time, and the cell RAM has one read port and one
// write port. After reset a clearing pass writes all GRID_WIDTH*GRID_HEIGHT
// cells (4096 by default) empty. No command beat is taken during that pass.
// A read passes through S_RRD and S_RWT to S_DONE, where the result beat is
// loaded. The unused command and a paint with an invalid type go straight to
// S_DONE.
// A sweep visits every cell of all rows but the last:
//   - a cell that is not sand or water is read in S_SRD and checked in S_SCHK;
//   - a falling cell reads and checks each neighbor in S_SNRD and S_SNCHK,
//     skips one at the grid edge in S_SNRD alone, and moves in S_SMV1, S_SMV2;
//   - the result is then loaded in S_DONE.
// A paint scans the (2r+1)^2 box. A cell outside the disc or the grid passes
// S_PRD alone, any other cell S_PRD and S_PCHK; the result is loaded in S_DONE.
// The result beat sits in an output register, so the next command is taken
// while it waits. That command holds in its last step until the register is
// free.
module falling_sand_grid_engine #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64,
    parameter int MAX_RADIUS  = 15
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_stall,
    input  wire [1:0]    i_command,
    input  wire [5:0]    i_pos_x,
    input  wire [5:0]    i_pos_y,
    input  wire [3:0]    i_brush_radius,
    output logic         o_valid,
    input  wire          i_stall,
    output logic [2:0]   o_cell_kind,
    output logic [7:0]   o_cell_weight,
    output logic         o_finished,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire [0:0]    i_cfg_index,
    input  wire [15:0]   i_cfg_data
);
    import fsge_pkg::*;

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW = $clog2(CELLS);
    // signed coordinates and brush offsets, room for a side of 1024 cells
    localparam int CW = 12;
    localparam logic signed [CW-1:0] GW_C  = CW'(GRID_WIDTH);
    localparam logic signed [CW-1:0] GH_C  = CW'(GRID_HEIGHT);
    localparam logic signed [CW-1:0] ONE_C = CW'(1);

    localparam logic [1:0] TRY_DOWN   = 2'd0;
    localparam logic [1:0] TRY_DLEFT  = 2'd1;
    localparam logic [1:0] TRY_DRIGHT = 2'd2;
    localparam logic [1:0] TRY_SIDE   = 2'd3;

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_RRD   = 13'b0000000000100,
        S_RWT   = 13'b0000000001000,
        S_SRD   = 13'b0000000010000,
        S_SCHK  = 13'b0000000100000,
        S_SNRD  = 13'b0000001000000,
        S_SNCHK = 13'b0000010000000,
        S_SMV1  = 13'b0000100000000,
        S_SMV2  = 13'b0001000000000,
        S_PRD   = 13'b0010000000000,
        S_PCHK  = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_clr;
    logic [2:0] r_ptype;
    logic [15:0] r_lfsr;
    t_cmd r_cmd;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [CW-1:0] r_dx, r_dy, r_r;
    logic [1:0] r_try;
    logic [2:0] r_k;
    logic [7:0] r_w;
    logic [AW-1:0] r_taddr;
    logic r_ov;
    logic [2:0] r_ok;
    logic [7:0] r_ow;
    logic r_of;

    // RAM ports
    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [10:0] ram_wdata, ram_rdata;
    logic [2:0] rd_kind;

    fsge_ram #(.WIDTH(11), .DEPTH(CELLS)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    function automatic logic [AW-1:0] addr_of(input logic signed [CW-1:0] x,
                                              input logic signed [CW-1:0] y);
        return AW'(32'(y) * GRID_WIDTH + 32'(x));
    endfunction

    logic accept;
    logic cfg_we;
    logic done_fire;
    assign o_stall = r_state != S_IDLE;
    assign accept = i_valid && !o_stall;
    assign o_cfg_ready = r_state == S_IDLE;
    assign cfg_we = i_cfg_valid && o_cfg_ready;
    assign o_valid = r_ov;
    assign o_cell_kind = r_ok;
    assign o_cell_weight = r_ow;
    assign o_finished = r_of;
    assign rd_kind = ram_rdata[10:8];
    // hold the last step while the previous beat is still stalled
    assign done_fire = (r_state == S_DONE) && (!r_ov || !i_stall);

    logic [3:0] rad_sat;
    assign rad_sat = (32'(i_brush_radius) > MAX_RADIUS) ? 4'(MAX_RADIUS) : i_brush_radius;

    logic [15:0] lfsr_step;
    assign lfsr_step = r_lfsr[0] ? ((r_lfsr >> 1) ^ LFSR_MASK) : (r_lfsr >> 1);

    // sweep bookkeeping
    logic x_first, x_last, sw_last, give_up, is_mover;
    assign x_first = r_x == '0;
    assign x_last = r_x == GW_C - ONE_C;
    assign sw_last = x_last && r_y == '0;
    assign give_up = (r_try == TRY_SIDE) || (r_try == TRY_DRIGHT && r_k != KIND_WATER);
    assign is_mover = rd_kind == KIND_SAND || rd_kind == KIND_WATER;

    // paint bookkeeping
    logic signed [CW-1:0] px, py, disc_d, disc_r;
    logic p_in, in_disc, pt_last, paint_ok, rd_in;
    assign px = r_cx + r_dx;
    assign py = r_cy + r_dy;
    assign p_in = !px[CW-1] && px < GW_C && !py[CW-1] && py < GH_C;
    assign disc_d = r_dx * r_dx + r_dy * r_dy;
    assign disc_r = r_r * r_r;
    assign in_disc = disc_d <= disc_r;
    assign pt_last = r_dx == r_r && r_dy == r_r;
    assign paint_ok = r_ptype >= KIND_SAND && r_ptype <= KIND_WOOD;
    assign rd_in = r_cx < GW_C && r_cy < GH_C;

    // neighbor target for the current try
    logic signed [CW-1:0] nx, ny;
    logic nb_ok;

    always_comb begin
        nx = r_x;
        ny = r_y + ONE_C;
        nb_ok = 1'b1;
        case (r_try)
            TRY_DOWN: begin
                nx = r_x;
            end
            TRY_DLEFT: begin
                nx = r_x - ONE_C;
                nb_ok = !x_first;
            end
            TRY_DRIGHT: begin
                nx = r_x + ONE_C;
                nb_ok = !x_last;
            end
            default: begin
                ny = r_y;
                if (!lfsr_step[0]) begin
                    nx = r_x - ONE_C;
                    nb_ok = !x_first;
                end else begin
                    nx = r_x + ONE_C;
                    nb_ok = !x_last;
                end
            end
        endcase
    end

    logic sw_adv, try_inc, pt_adv;

    always_comb begin
        n_state = r_state;
        ram_we = 1'b0;
        ram_waddr = addr_of(r_x, r_y);
        ram_wdata = '0;
        ram_raddr = addr_of(r_x, r_y);
        sw_adv = 1'b0;
        try_inc = 1'b0;
        pt_adv = 1'b0;
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                ram_waddr = r_clr;
                if (r_clr == AW'(CELLS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    case (t_cmd'(i_command))
                        CMD_SWEEP: n_state = S_SRD;
                        CMD_PAINT: n_state = paint_ok ? S_PRD : S_DONE;
                        CMD_READ:  n_state = S_RRD;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_RRD: begin
                ram_raddr = addr_of(r_cx, r_cy);
                n_state = S_RWT;
            end
            S_RWT: n_state = S_DONE;
            S_SRD: n_state = S_SCHK;
            S_SCHK: begin
                if (is_mover) begin
                    n_state = S_SNRD;
                end else begin
                    sw_adv = 1'b1;
                    n_state = sw_last ? S_DONE : S_SRD;
                end
            end
            S_SNRD: begin
                ram_raddr = addr_of(nx, ny);
                if (nb_ok) begin
                    n_state = S_SNCHK;
                end else if (give_up) begin
                    sw_adv = 1'b1;
                    n_state = sw_last ? S_DONE : S_SRD;
                end else begin
                    try_inc = 1'b1;
                end
            end
            S_SNCHK: begin
                if (rd_kind == KIND_EMPTY) begin
                    n_state = S_SMV1;
                end else if (give_up) begin
                    sw_adv = 1'b1;
                    n_state = sw_last ? S_DONE : S_SRD;
                end else begin
                    try_inc = 1'b1;
                    n_state = S_SNRD;
                end
            end
            S_SMV1: begin
                ram_we = 1'b1;
                ram_waddr = r_taddr;
                ram_wdata = {r_k, r_w};
                n_state = S_SMV2;
            end
            S_SMV2: begin
                // empty the source cell
                ram_we = 1'b1;
                sw_adv = 1'b1;
                n_state = sw_last ? S_DONE : S_SRD;
            end
            S_PRD: begin
                if (p_in && in_disc) begin
                    ram_raddr = addr_of(px, py);
                    n_state = S_PCHK;
                end else begin
                    pt_adv = 1'b1;
                    n_state = pt_last ? S_DONE : S_PRD;
                end
            end
            S_PCHK: begin
                ram_waddr = addr_of(px, py);
                ram_wdata = {r_ptype, kind_mass(r_ptype)};
                ram_we = rd_kind == KIND_EMPTY;
                pt_adv = 1'b1;
                n_state = pt_last ? S_DONE : S_PRD;
            end
            S_DONE: begin
                if (done_fire) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_ptype <= KIND_SAND;
            r_lfsr <= 16'd1;
            r_cmd <= CMD_SWEEP;
            r_x <= '0;
            r_y <= '0;
            r_cx <= '0;
            r_cy <= '0;
            r_dx <= '0;
            r_dy <= '0;
            r_r <= '0;
            r_try <= TRY_DOWN;
            r_k <= KIND_EMPTY;
            r_w <= '0;
            r_taddr <= '0;
            r_ov <= 1'b0;
            r_ok <= '0;
            r_ow <= '0;
            r_of <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov <= done_fire || (r_ov && i_stall);
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (cfg_we && i_cfg_index == REG_PAINT_TYPE) r_ptype <= i_cfg_data[2:0];
            if (cfg_we && i_cfg_index == REG_RANDOM_SEED) begin
                r_lfsr <= (i_cfg_data == 16'd0) ? 16'd1 : i_cfg_data;
            end else if (r_state == S_SNRD && r_try == TRY_SIDE) begin
                r_lfsr <= lfsr_step;
            end
            if (accept) begin
                r_cmd <= t_cmd'(i_command);
                r_x <= '0;
                r_y <= GH_C - CW'(2);
                r_cx <= CW'(i_pos_x);
                r_cy <= CW'(i_pos_y);
                r_r <= CW'(rad_sat);
                r_dx <= -CW'(rad_sat);
                r_dy <= -CW'(rad_sat);
            end
            if (sw_adv) begin
                if (x_last) begin
                    r_x <= '0;
                    r_y <= r_y - ONE_C;
                end else begin
                    r_x <= r_x + ONE_C;
                end
            end
            if (accept || sw_adv) r_try <= TRY_DOWN;
            else if (try_inc) r_try <= r_try + 1'b1;
            if (pt_adv) begin
                if (r_dx == r_r) begin
                    r_dx <= -r_r;
                    r_dy <= r_dy + ONE_C;
                end else begin
                    r_dx <= r_dx + ONE_C;
                end
            end
            if (r_state == S_SCHK) begin
                r_k <= rd_kind;
                r_w <= ram_rdata[7:0];
            end else if (r_state == S_RWT) begin
                r_k <= rd_in ? rd_kind : KIND_EMPTY;
                r_w <= (rd_in && rd_kind != KIND_EMPTY) ? ram_rdata[7:0] : 8'd0;
            end
            if (r_state == S_SNRD) r_taddr <= addr_of(nx, ny);
            if (done_fire) begin
                r_of <= r_cmd != CMD_NONE;
                r_ok <= (r_cmd == CMD_READ) ? r_k : KIND_EMPTY;
                r_ow <= (r_cmd == CMD_READ) ? r_w : 8'd0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the falling sand grid engine: every result beat is compared with a
// grid model kept here. The model covers sweeps, brush paints and cell reads.
// ----------------------------------------------------------------------------
// Directed tests cover reads of an empty grid, paints at the edges of the grid
// and onto filled cells, every paint type including invalid ones, falling
// sand, sideways water and the unused command. A random part follows. It is
// split into phases, and the registers are rewritten between phases. The
// sender works in bursts and the receiver stalls on a pattern of its own.
module testbench;
    import fsge_pkg::*;

    localparam int GW        = 64;
    localparam int GH        = 64;
    localparam int RAD_LIMIT = 15;
    localparam int IDLE_MAX  = 200000;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] weight;
        logic       done;
    } t_cell_beat;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [1:0]  i_command      = '0;
    logic [5:0]  i_pos_x        = '0;
    logic [5:0]  i_pos_y        = '0;
    logic [3:0]  i_brush_radius = '0;
    logic        i_stall        = 1'b0;
    logic        i_cfg_valid    = 1'b0;
    logic [0:0]  i_cfg_index    = '0;
    logic [15:0] i_cfg_data     = '0;
    wire         o_stall;
    wire         o_valid;
    wire  [2:0]  o_cell_kind;
    wire  [7:0]  o_cell_weight;
    wire         o_finished;
    wire         o_cfg_ready;

    falling_sand_grid_engine i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_brush_radius (i_brush_radius),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_cell_kind    (o_cell_kind),
        .o_cell_weight  (o_cell_weight),
        .o_finished     (o_finished),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // grid model
    logic [2:0]  grid_kind [GW*GH];
    logic [7:0]  grid_weight [GW*GH];
    logic [15:0] dir_lfsr;
    logic [2:0]  brush_kind;

    t_cell_beat  pending_beats[$];
    int          error_count;
    int          sweep_count;
    int          paint_count;
    int          read_count;
    int          cfg_count;
    int          burst_left;
    bit          valid_high;

    function automatic logic [7:0] brush_mass(input logic [2:0] k);
        case (k)
            KIND_SAND:  return 8'd100;
            KIND_WATER: return 8'd50;
            KIND_STONE: return 8'd200;
            KIND_WOOD:  return 8'd150;
            default:    return 8'd0;
        endcase
    endfunction

    function automatic bit is_free(input int x, input int y);
        return grid_kind[y*GW + x] == KIND_EMPTY;
    endfunction

    function automatic void move_cell(input int sx, input int sy, input int tx, input int ty);
        grid_kind[ty*GW + tx]   = grid_kind[sy*GW + sx];
        grid_weight[ty*GW + tx] = grid_weight[sy*GW + sx];
        grid_kind[sy*GW + sx]   = KIND_EMPTY;
        grid_weight[sy*GW + sx] = 8'd0;
    endfunction

    // advance the Galois LFSR; low bit 0 picks left
    function automatic bit step_dir_left();
        logic lsb;
        lsb = dir_lfsr[0];
        dir_lfsr = dir_lfsr >> 1;
        if (lsb)
            dir_lfsr = dir_lfsr ^ LFSR_MASK;
        return dir_lfsr[0] == 1'b0;
    endfunction

    function automatic void sweep_grid_model();
        logic [2:0] k;
        for (int y = GH - 2; y >= 0; y--) begin
            for (int x = 0; x < GW; x++) begin
                k = grid_kind[y*GW + x];
                if (k != KIND_SAND && k != KIND_WATER)
                    continue;
                if (is_free(x, y + 1))
                    move_cell(x, y, x, y + 1);
                else if (x > 0 && is_free(x - 1, y + 1))
                    move_cell(x, y, x - 1, y + 1);
                else if (x < GW - 1 && is_free(x + 1, y + 1))
                    move_cell(x, y, x + 1, y + 1);
                else if (k == KIND_WATER) begin
                    if (step_dir_left()) begin
                        if (x > 0 && is_free(x - 1, y))
                            move_cell(x, y, x - 1, y);
                    end else begin
                        if (x < GW - 1 && is_free(x + 1, y))
                            move_cell(x, y, x + 1, y);
                    end
                end
            end
        end
    endfunction

    function automatic void paint_disc_model(input int cx, input int cy, input int r);
        int x;
        int y;
        if (brush_kind < KIND_SAND || brush_kind > KIND_WOOD)
            return;
        if (r > RAD_LIMIT)
            r = RAD_LIMIT;
        for (int dy = -r; dy <= r; dy++) begin
            for (int dx = -r; dx <= r; dx++) begin
                x = cx + dx;
                y = cy + dy;
                if (dx*dx + dy*dy > r*r)
                    continue;
                if (x < 0 || x >= GW || y < 0 || y >= GH)
                    continue;
                if (!is_free(x, y))
                    continue;
                grid_kind[y*GW + x]   = brush_kind;
                grid_weight[y*GW + x] = brush_mass(brush_kind);
            end
        end
    endfunction

    function automatic t_cell_beat run_command(input t_cmd cmd, input int px, input int py,
                                               input int r);
        t_cell_beat b;
        b = '0;
        case (cmd)
            CMD_SWEEP: begin
                sweep_grid_model();
                b.done = 1'b1;
            end
            CMD_PAINT: begin
                paint_disc_model(px, py, r);
                b.done = 1'b1;
            end
            CMD_READ: begin
                b.kind   = grid_kind[py*GW + px];
                b.weight = (b.kind == KIND_EMPTY) ? 8'd0 : grid_weight[py*GW + px];
                b.done   = 1'b1;
            end
            default: b = '0;
        endcase
        return b;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // receiver: stall pattern and result check
    int stall_mode;
    int stall_span;
    always @(posedge i_clk) begin
        t_cell_beat want;
        if (o_valid && !i_stall) begin
            if (pending_beats.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                want = pending_beats.pop_front();
                if (o_cell_kind !== want.kind)
                    report_mismatch("cell_kind", o_cell_kind, want.kind);
                if (o_cell_weight !== want.weight)
                    report_mismatch("cell_weight", o_cell_weight, want.weight);
                if (o_finished !== want.done)
                    report_mismatch("finished", o_finished, want.done);
            end
        end
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_span <= $urandom_range(5, 60);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // watchdog on cycles without any beat
    int idle_cycles;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("timeout after %0d cycles without a beat", IDLE_MAX);
            $display("FAIL falling_sand_grid_engine");
            $finish;
        end
    end

    initial begin
        stall_mode  = 0;
        stall_span  = 0;
        idle_cycles = 0;
    end

    task automatic send_item(input t_cmd cmd, input int px, input int py, input int r);
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_pos_x        <= px[5:0];
        i_pos_y        <= py[5:0];
        i_brush_radius <= r[3:0];
        valid_high = 1'b1;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        pending_beats.push_back(run_command(cmd, px, py, r));
        case (cmd)
            CMD_SWEEP: sweep_count++;
            CMD_PAINT: paint_count++;
            CMD_READ:  read_count++;
            default: ;
        endcase
        // hold valid through the burst, then drop it for a gap
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            valid_high = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(0, 6);
        end
    endtask

    task automatic drain();
        if (valid_high) begin
            i_valid <= 1'b0;
            valid_high = 1'b0;
            @(posedge i_clk);
        end
        while (pending_beats.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_count++;
        if (idx == REG_PAINT_TYPE) begin
            brush_kind = value[2:0];
        end else begin
            dir_lfsr = (value == 16'd0) ? 16'd1 : value;
        end
        @(posedge i_clk);
    endtask

    task automatic test_empty_reads();
        send_item(CMD_READ, 0, 0, 0);
        send_item(CMD_READ, 63, 63, 15);
        send_item(CMD_READ, 63, 0, 0);
        send_item(CMD_READ, 0, 63, 0);
    endtask

    task automatic test_paint_edges();
        send_item(CMD_PAINT, 0, 0, 0);
        send_item(CMD_PAINT, 63, 63, 15);
        send_item(CMD_READ, 63, 63, 0);
        write_reg(REG_PAINT_TYPE, 16'(KIND_STONE));
        // overlap the filled disc; filled cells keep their kind
        send_item(CMD_PAINT, 60, 60, 4);
        send_item(CMD_READ, 60, 60, 0);
        send_item(CMD_READ, 48, 63, 0);
    endtask

    task automatic test_paint_types();
        write_reg(REG_PAINT_TYPE, 16'(KIND_WOOD));
        send_item(CMD_PAINT, 10, 30, 1);
        send_item(CMD_READ, 10, 30, 0);
        write_reg(REG_PAINT_TYPE, 16'd0);
        send_item(CMD_PAINT, 30, 10, 3);
        write_reg(REG_PAINT_TYPE, 16'hFFFF);
        send_item(CMD_PAINT, 31, 10, 3);
        send_item(CMD_READ, 30, 10, 0);
    endtask

    task automatic test_falling_and_water();
        write_reg(REG_PAINT_TYPE, 16'(KIND_WATER));
        write_reg(REG_RANDOM_SEED, 16'd0);
        send_item(CMD_PAINT, 32, 55, 6);
        write_reg(REG_PAINT_TYPE, 16'(KIND_SAND));
        send_item(CMD_PAINT, 32, 40, 3);
        send_item(CMD_SWEEP, 0, 0, 0);
        send_item(CMD_SWEEP, 63, 63, 15);
        send_item(CMD_READ, 32, 62, 0);
        send_item(CMD_NONE, 63, 63, 15);
    endtask

    task automatic test_random_mix(input int count);
        int pick;
        int rx;
        int ry;
        int rr;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            rx = $urandom_range(0, 63);
            ry = $urandom_range(0, 63);
            rr = $urandom_range(0, 15);
            if (pick < 45)
                send_item(CMD_READ, rx, ry, rr);
            else if (pick < 78)
                send_item(CMD_PAINT, rx, ry,
                          ($urandom_range(0, 9) == 0) ? 15 : $urandom_range(0, 6));
            else if (pick < 95)
                send_item(CMD_SWEEP, rx, ry, rr);
            else
                send_item(CMD_NONE, rx, ry, rr);
        end
    endtask

    task automatic test_random_phases();
        logic [15:0] seeds[4];
        seeds = '{16'hFFFF, 16'd1, 16'd0, 16'hACE1};
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_PAINT_TYPE, ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 7))
                                                                  : 16'($urandom_range(1, 4)));
            write_reg(REG_RANDOM_SEED, (ph == 3) ? 16'($urandom) : seeds[ph]);
            test_random_mix(20);
        end
    endtask

    initial begin
        for (int i = 0; i < GW*GH; i++) begin
            grid_kind[i]   = KIND_EMPTY;
            grid_weight[i] = 8'd0;
        end
        dir_lfsr    = 16'd1;
        brush_kind  = KIND_SAND;
        error_count = 0;
        sweep_count = 0;
        paint_count = 0;
        read_count  = 0;
        cfg_count   = 0;
        burst_left  = 0;
        valid_high  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_reads();
        test_paint_edges();
        test_paint_types();
        test_falling_and_water();
        test_random_phases();
        drain();

        $display("covered %0d sweeps, %0d paints, %0d reads, %0d register writes",
                 sweep_count, paint_count, read_count, cfg_count);
        $display("mismatches found: %0d", error_count);
        if (error_count == 0)
            $display("PASS falling_sand_grid_engine");
        else
            $display("FAIL falling_sand_grid_engine");
        $finish;
    end
endmodule
